// ===== hdl/ptsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsi_pkg
// Shared command and status types between the subtree invalidate controller
// and its datapath.
// ----------------------------------------------------------------------------
package ptsi_pkg;

  // Operation codes of an input item
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Field widths fixed by the item format
  localparam int unsigned LINK_W  = 7;
  localparam int unsigned COUNT_W = 7;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;    // register the accepted item
    logic load;       // write parent link, mark entry valid
    logic del_start;  // invalidate named entry, restart sweep at entry 0
    logic i_inc;      // advance sweep position
    logic kill;       // invalidate sweep entry and advance
    logic rd_scan;    // read parent of sweep entry, restart step count
    logic rd_walk;    // read parent of the link just returned, count step
    logic out_load;   // load result register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_ok;     // captured index within the table
    logic op_del;     // captured operation is a delete
    logic idx_alive;  // captured entry currently valid
    logic scan_done;  // sweep passed the last entry
    logic cur_alive;  // sweep entry currently valid
    logic par_ok;     // returned link within the table
    logic par_alive;  // entry named by returned link is valid
    logic step_last;  // chain walk used its last step
  } status_t;

endpackage

// ===== hdl/ptsi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsi_in_if / ptsi_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ptsi_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic signed [ptsi_pkg::LINK_W-1:0] entry_index;
  logic signed [ptsi_pkg::LINK_W-1:0] parent_link;

  modport source (output valid, operation, entry_index, parent_link, input ready);
  modport sink   (input valid, operation, entry_index, parent_link, output ready);
endinterface

interface ptsi_out_if;
  logic                           valid;
  logic                           ready;
  logic [ptsi_pkg::COUNT_W-1:0]   live_count;
  logic                           entry_alive;

  modport source (output valid, live_count, entry_alive, input ready);
  modport sink   (input valid, live_count, entry_alive, output ready);
endinterface

// ===== hdl/ptsi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptsi_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ptsi_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsi_datapath
// Parent link RAM, valid marks, live count, sweep and step counters and the
// result register.
// ----------------------------------------------------------------------------
module ptsi_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptsi_pkg::cmd_t                cmd,
  output ptsi_pkg::status_t             status,
  input  logic                          in_operation,
  input  logic [ptsi_pkg::LINK_W-1:0]   in_entry_index,
  input  logic [ptsi_pkg::LINK_W-1:0]   in_parent_link,
  output logic [ptsi_pkg::COUNT_W-1:0]  out_live_count,
  output logic                          out_entry_alive
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // Link within the table: non-negative and below ENTRIES
  function automatic logic link_ok(input logic [ptsi_pkg::LINK_W-1:0] v);
    logic [31:0] wide;
    wide = {{(32 - ptsi_pkg::LINK_W){1'b0}}, v};
    return !v[ptsi_pkg::LINK_W-1] && (wide < 32'(ENTRIES));
  endfunction

  function automatic logic [IW-1:0] to_idx(input logic [ptsi_pkg::LINK_W-1:0] v);
    logic [31:0] wide;
    wide = {{(32 - ptsi_pkg::LINK_W){1'b0}}, v};
    return wide[IW-1:0];
  endfunction

  logic                          op_r;
  logic [ptsi_pkg::LINK_W-1:0]   idx_r;
  logic [ptsi_pkg::LINK_W-1:0]   par_r;
  logic [ENTRIES-1:0]            alive_r, alive_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 i_r, i_nxt;
  logic [IW-1:0]                 step_r;
  logic [ptsi_pkg::COUNT_W-1:0]  live_count_r;
  logic                          entry_alive_r;
  logic [ptsi_pkg::LINK_W-1:0]   rdata;
  logic [IW-1:0]                 raddr;
  logic [IW-1:0]                 idx_sel;
  logic [IW-1:0]                 i_sel;
  logic [31:0]                   count_wide;

  assign idx_sel = to_idx(idx_r);
  assign i_sel   = i_r[IW-1:0];

  // Parent link store
  assign raddr = cmd.rd_scan ? i_sel : to_idx(rdata);

  ptsi_ram #(
    .WIDTH (ptsi_pkg::LINK_W),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (idx_sel),
    .wdata (par_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller
  always_comb begin
    status.idx_ok    = link_ok(idx_r);
    status.op_del    = (op_r == ptsi_pkg::OP_DELETE);
    status.idx_alive = link_ok(idx_r) && alive_r[idx_sel];
    status.scan_done = (i_r == CW'(ENTRIES));
    status.cur_alive = !status.scan_done && alive_r[i_sel];
    status.par_ok    = link_ok(rdata);
    status.par_alive = link_ok(rdata) && alive_r[to_idx(rdata)];
    status.step_last = (step_r == IW'(ENTRIES - 1));
  end

  // Next valid marks, count and sweep position
  always_comb begin
    alive_nxt = alive_r;
    count_nxt = count_r;
    i_nxt     = i_r;
    if (cmd.load) begin
      alive_nxt[idx_sel] = 1'b1;
      if (!alive_r[idx_sel]) begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.del_start) begin
      alive_nxt[idx_sel] = 1'b0;
      i_nxt              = '0;
      if (count_r != '0) begin
        count_nxt = count_r - CW'(1);
      end
    end
    if (cmd.kill) begin
      alive_nxt[i_sel] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - CW'(1);
      end
    end
    if (cmd.i_inc || cmd.kill) begin
      i_nxt = i_r + CW'(1);
    end
  end

  // Control state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r <= '0;
      count_r <= '0;
      i_r     <= '0;
    end else begin
      alive_r <= alive_nxt;
      count_r <= count_nxt;
      i_r     <= i_nxt;
    end
  end

  // Hold the accepted item and the chain step count
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      idx_r <= in_entry_index;
      par_r <= in_parent_link;
    end
    if (cmd.rd_scan) begin
      step_r <= '0;
    end else if (cmd.rd_walk) begin
      step_r <= step_r + IW'(1);
    end
  end

  // Result register
  assign count_wide = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      live_count_r  <= count_wide[ptsi_pkg::COUNT_W-1:0];
      entry_alive_r <= status.idx_alive;
    end
  end

  assign out_live_count  = live_count_r;
  assign out_entry_alive = entry_alive_r;

endmodule

// ===== hdl/ptsi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsi_ctrl
// Sequencer for load, delete sweep and chain walk, plus output valid.
// ----------------------------------------------------------------------------
module ptsi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ptsi_pkg::status_t  status,
  output ptsi_pkg::cmd_t     cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_WALK   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.idx_ok && !status.op_del) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FINISH;
        end else if (status.idx_ok && status.op_del && status.idx_alive) begin
          cmd.del_start = 1'b1;
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_FINISH;
        end else if (!status.cur_alive) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!status.par_ok) begin
          // chain ends at a root: entry survives
          cmd.i_inc = 1'b1;
          state_nxt = ST_SCAN;
        end else if (!status.par_alive) begin
          // chain reaches an invalid ancestor: drop the entry
          cmd.kill  = 1'b1;
          state_nxt = ST_SCAN;
        end else if (status.step_last) begin
          // walk bound reached on a loop: entry survives
          cmd.i_inc = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          cmd.rd_walk = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, clear on transfer
  always_comb begin
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/parent_table_subtree_invalidate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parent_table_subtree_invalidate_unit
// Parent table with valid marks and live count; load and subtree delete.
// ----------------------------------------------------------------------------
// One item is worked at a time: the unit takes a new item in only once the
// result of the last one is loaded into the output register. A load, an
// out-of-range index or a delete of an invalid entry goes from ST_EXEC
// straight to ST_FINISH. A delete of a valid entry sweeps the table and, for
// each entry still valid when the sweep reaches it, follows its chain up, at
// most ENTRIES links, one link per cycle through the single read port of the
// parent link RAM. A finished result waits in the output register while the
// next item is taken in.
// ----------------------------------------------------------------------------
module parent_table_subtree_invalidate_unit #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  ptsi_in_if.sink           in_ch,
  ptsi_out_if.source        out_ch
);

  ptsi_pkg::cmd_t    cmd;
  ptsi_pkg::status_t status;

  ptsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ptsi_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_operation    (in_ch.operation),
    .in_entry_index  (in_ch.entry_index),
    .in_parent_link  (in_ch.parent_link),
    .out_live_count  (out_ch.live_count),
    .out_entry_alive (out_ch.entry_alive)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parent table subtree invalidate unit. A
// scoreboard class keeps its own copy of the parent links, valid marks and
// live count. It works out the count and the addressed valid mark for each
// transfer in, and compares every transfer out with the oldest expectation.
// Stimulus is a short directed list followed by random forest builds, deep
// chains, full-table fills, subtree deletes and noise. Both channels idle in
// random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [ptsi_pkg::COUNT_W-1:0] count;
  logic                         alive;
} tally_t;

class subtree_scoreboard;
  localparam int SLOTS = 64;

  logic signed [ptsi_pkg::LINK_W-1:0] link_of [SLOTS];
  bit                                 live [SLOTS];
  bit [ptsi_pkg::COUNT_W-1:0]         live_total;
  tally_t                             expected_q [$];
  int                                 mismatches;

  function new();
    live_total = '0;
    mismatches = 0;
    foreach (live[i]) live[i] = 1'b0;
  endfunction

  // True when the valid ancestors above a slot lead to an invalid entry
  function bit chain_reaches_dead(int slot);
    int cur;
    int up;
    cur = slot;
    for (int step = 0; step < SLOTS; step++) begin
      up = link_of[cur];
      if (up < 0 || up >= SLOTS) return 1'b0;
      if (!live[up]) return 1'b1;
      cur = up;
    end
    return 1'b0;
  endfunction

  // Apply one accepted item to the table and queue the result it must give
  function void note_input(logic op, logic signed [ptsi_pkg::LINK_W-1:0] idx,
                           logic signed [ptsi_pkg::LINK_W-1:0] par);
    int     slot;
    bit     swept [SLOTS];
    tally_t want;
    slot = idx;
    if (slot >= 0 && slot < SLOTS) begin
      if (op == ptsi_pkg::OP_LOAD) begin
        link_of[slot] = par;
        if (!live[slot]) begin
          live[slot] = 1'b1;
          live_total++;
        end
      end else if (live[slot]) begin
        // drop the named entry, then sweep in index order
        foreach (swept[i]) swept[i] = 1'b0;
        live[slot] = 1'b0;
        if (live_total > 0) live_total--;
        swept[slot] = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (swept[i] || !live[i]) continue;
          if (chain_reaches_dead(i)) begin
            live[i] = 1'b0;
            if (live_total > 0) live_total--;
          end
          swept[i] = 1'b1;
        end
      end
    end
    want.count = live_total;
    want.alive = (slot >= 0 && slot < SLOTS) ? live[slot] : 1'b0;
    expected_q.push_back(want);
  endfunction

  function void flag(string what);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, what);
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_result(logic [ptsi_pkg::COUNT_W-1:0] count, logic alive);
    tally_t want;
    if (expected_q.size() == 0) begin
      flag($sformatf("unexpected result: count %0d alive %0b", count, alive));
      return;
    end
    want = expected_q.pop_front();
    if (count !== want.count || alive !== want.alive)
      flag($sformatf("result mismatch: expected count %0d alive %0b, got count %0d alive %0b",
                     want.count, want.alive, count, alive));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  localparam int ENTRIES     = 64;
  localparam int ITEM_TARGET = 400;
  localparam int CALM_AFTER  = 340;
  // worst case: every item a full sweep with the longest chains, plus stalls
  localparam int CYCLE_LIMIT = 8_000_000;

  logic clk;
  logic rst_n;
  int   cycles;
  int   items_sent;
  bit   quiet_tail;

  subtree_scoreboard sb;

  ptsi_in_if  in_ch ();
  ptsi_out_if out_ch ();

  parent_table_subtree_invalidate_unit #(.ENTRIES(ENTRIES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.live_count, out_ch.entry_alive);
  end

  // Result side: random stall bursts, none in the closing stretch
  initial begin
    int run;
    out_ch.ready = 1'b0;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        run = $urandom_range(1, 13);
        repeat (run) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end else begin
        run = $urandom_range(1, 20);
        repeat (run) begin
          @(negedge clk);
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Hold valid low for a random burst
  task automatic idle_burst();
    int run;
    run = $urandom_range(1, 13);
    repeat (run) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Drive one item and hold it until the transfer, then note it
  task automatic issue(logic op, int idx, int par);
    if (!quiet_tail && $urandom_range(0, 4) == 0) idle_burst();
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.entry_index <= idx[ptsi_pkg::LINK_W-1:0];
    in_ch.parent_link <= par[ptsi_pkg::LINK_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(in_ch.operation, in_ch.entry_index, in_ch.parent_link);
    items_sent++;
    if (items_sent >= CALM_AFTER) quiet_tail = 1'b1;
  endtask

  function automatic int pick_live_slot();
    int picks [$];
    for (int i = 0; i < ENTRIES; i++)
      if (sb.live[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(0, picks.size() - 1)];
  endfunction

  // Mostly a live parent, sometimes a negative root, sometimes a stale link
  function automatic int pick_parent();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return pick_live_slot();
    if (r < 8) return $urandom_range(64, 127);
    return $urandom_range(0, ENTRIES - 1);
  endfunction

  task automatic directed_items();
    // build a chain 0 <- 63 <- 1 <- 2
    issue(ptsi_pkg::OP_LOAD, 0, -1);
    issue(ptsi_pkg::OP_LOAD, 63, 0);
    issue(ptsi_pkg::OP_LOAD, 1, 63);
    issue(ptsi_pkg::OP_LOAD, 2, 1);
    // out-of-range loads and deletes, delete of an invalid entry
    issue(ptsi_pkg::OP_LOAD, -1, 5);
    issue(ptsi_pkg::OP_LOAD, -64, 63);
    issue(ptsi_pkg::OP_DELETE, -64, -64);
    issue(ptsi_pkg::OP_DELETE, -1, 0);
    issue(ptsi_pkg::OP_DELETE, 5, 0);
    // rewrite of an entry already valid
    issue(ptsi_pkg::OP_LOAD, 1, 63);
    // stale link to an invalid parent
    issue(ptsi_pkg::OP_LOAD, 10, 11);
    // cyclic links with a hanging child
    issue(ptsi_pkg::OP_LOAD, 20, 21);
    issue(ptsi_pkg::OP_LOAD, 21, 20);
    issue(ptsi_pkg::OP_LOAD, 22, 20);
    // root marked by the most negative link
    issue(ptsi_pkg::OP_LOAD, 30, -64);
    issue(ptsi_pkg::OP_LOAD, 31, 30);
    issue(ptsi_pkg::OP_LOAD, 32, 31);
    // cascade from the root of the first chain, then again on a dead entry
    issue(ptsi_pkg::OP_DELETE, 0, 0);
    issue(ptsi_pkg::OP_DELETE, 0, 0);
    // leaf delete, then subtree delete
    issue(ptsi_pkg::OP_DELETE, 32, 0);
    issue(ptsi_pkg::OP_DELETE, 30, 0);
    // break the cycle
    issue(ptsi_pkg::OP_DELETE, 21, 0);
    issue(ptsi_pkg::OP_DELETE, 63, 0);
  endtask

  task automatic random_items();
    int kind;
    int n;
    int base;
    int prev;
    int fills;
    int order [ENTRIES];
    int tmp;
    int j;
    int tgt;
    fills = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind == 9 && fills >= 2) kind = 5;
      case (kind)
        0, 1, 2, 3: begin
          // grow a forest
          n = $urandom_range(1, 16);
          repeat (n) issue(ptsi_pkg::OP_LOAD, $urandom_range(0, ENTRIES - 1),
                           pick_parent());
        end
        4: begin
          // deep chain with falling indexes so the sweep walks far
          n    = $urandom_range(2, 40);
          base = $urandom_range(0, ENTRIES - 1);
          prev = pick_live_slot();
          for (int k = 0; k < n; k++) begin
            tmp = (base - k + ENTRIES) % ENTRIES;
            issue(ptsi_pkg::OP_LOAD, tmp, prev);
            prev = tmp;
          end
        end
        5, 6, 7: begin
          // subtree deletes, mostly of live entries
          n = $urandom_range(1, 5);
          repeat (n) begin
            tgt = pick_live_slot();
            if (tgt < 0 || $urandom_range(0, 4) == 0) tgt = $urandom_range(0, 127);
            issue(ptsi_pkg::OP_DELETE, tgt, $urandom_range(0, 127));
          end
        end
        8: begin
          // noise over the full field ranges
          n = $urandom_range(1, 6);
          repeat (n) issue(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                           $urandom_range(0, 127));
        end
        default: begin
          // fill the whole table in random order
          fills++;
          for (int i = 0; i < ENTRIES; i++) order[i] = i;
          for (int i = ENTRIES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
          for (int i = 0; i < ENTRIES; i++)
            issue(ptsi_pkg::OP_LOAD, order[i], pick_parent());
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    sb                = new();
    items_sent        = 0;
    quiet_tail        = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = ptsi_pkg::OP_LOAD;
    in_ch.entry_index = '0;
    in_ch.parent_link = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();
    random_items();
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain, then let the block settle
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
